// ----- hdl/maft_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maft_pkg
// Shared types and constants of the multistep attack flow table.
// ----------------------------------------------------------------------------
package maft_pkg;

	localparam int TABLE_ENTRIES_DEF = 16;
	localparam logic [15:0] EXPIRY_RESET = 16'd300;

	typedef enum logic [2:0] {
		ST_IGNORED   = 3'd0,
		ST_ADDED     = 3'd1,
		ST_FULL      = 3'd2,
		ST_TRACKED   = 3'd3,
		ST_ADVANCED  = 3'd4,
		ST_ATTACK    = 3'd5,
		ST_UNTRACKED = 3'd6,
		ST_BADKIND   = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		KIND_HTTP     = 2'd0,
		KIND_FTP_REQ  = 2'd1,
		KIND_FTP_DATA = 2'd2,
		KIND_OTHER    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		CTL_IDLE,
		CTL_SCAN,
		CTL_DONE
	} ctl_state_t;

	// One table entry as held in the memory. Step three is a flag; clear means step two.
	typedef struct packed {
		logic [31:0] addr;
		logic [31:0] created;
		logic        step3;
	} entry_t;

endpackage

// ----- hdl/multistep_attack_flow_table_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multistep_attack_flow_table_top
// Tracks HTTP target addresses and flags a later FTP follow-up as an attack.
// ----------------------------------------------------------------------------
// Usage:
// An event beat is taken on in_valid & in_ready and gives exactly one result
// beat (status, attack_alarm) on out_valid & out_ready. in_ready is high only
// while no event is in progress. An invalid event or one of the other kind
// skips the scan and goes straight to completion. Any other event scans the
// entry memory one entry per cycle through its single read port, stopping
// at the first matching address; a miss always costs the full scan.
// The result sits in an output register; the next event is accepted while it
// waits, and only the completion of that next event stalls until the
// receiver takes the pending beat.
// Reset clears every valid mark at once (empty table) and sets the expiry
// limit to 300 seconds; no clearing pass is needed. cfg_wr_en writes the
// expiry limit in the same cycle and must only be used while idle.
// ----------------------------------------------------------------------------
module multistep_attack_flow_table_top #(
	parameter int TABLE_ENTRIES = maft_pkg::TABLE_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        event_valid,
	input  logic [1:0]  event_kind,
	input  logic [31:0] dest_addr,
	input  logic [31:0] now_sec,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic        attack_alarm
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	maft_pkg::ctl_state_t state_q, state_d;

	logic [15:0] expiry_q;
	logic [TABLE_ENTRIES-1:0] slot_valid_q;
	logic [TABLE_ENTRIES-1:0] slot_valid_d;

	// Event being processed.
	maft_pkg::kind_t kind_q;
	logic [31:0] addr_q;
	logic [31:0] now_q;

	// Read issue side of the scan.
	logic             issue_act_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic             free_found_q;
	logic [IDX_W-1:0] free_idx_q;

	// Compare side, registered from the issue side.
	logic             cmp_act_s1;
	logic             cmp_vld_s1;
	logic [IDX_W-1:0] cmp_idx_s1;

	maft_pkg::entry_t rd_data;

	// Decided outcome, applied when the result is handed to the output register.
	maft_pkg::status_t res_status_q;
	logic              res_alarm_q;
	logic              wr_en_q;
	logic [IDX_W-1:0]  wr_idx_q;
	maft_pkg::entry_t  wr_data_q;
	logic              set_vld_q;
	logic [IDX_W-1:0]  set_idx_q;
	logic              clr_vld_q;
	logic [IDX_W-1:0]  clr_idx_q;

	logic              out_valid_q;
	maft_pkg::status_t out_status_q;
	logic              out_alarm_q;

	logic accept;
	logic issue;
	logic out_load;
	logic mem_we;

	logic        hit;
	logic        scan_end;
	logic        expired;
	logic [31:0] age;
	logic [IDX_W-1:0] add_idx;
	logic             add_ok;

	assign accept = in_valid && in_ready;

	// ---------------- control: next state ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			maft_pkg::CTL_IDLE: begin
				if (accept) begin
					if (event_valid && (maft_pkg::kind_t'(event_kind) != maft_pkg::KIND_OTHER))
						state_d = maft_pkg::CTL_SCAN;
					else
						state_d = maft_pkg::CTL_DONE;
				end
			end
			maft_pkg::CTL_SCAN: begin
				if (scan_end)
					state_d = maft_pkg::CTL_DONE;
			end
			maft_pkg::CTL_DONE: begin
				if (out_load)
					state_d = maft_pkg::CTL_IDLE;
			end
			default: state_d = maft_pkg::CTL_IDLE;
		endcase
	end

	// ---------------- control: outputs ----------------
	always_comb begin
		in_ready = 1'b0;
		issue    = 1'b0;
		out_load = 1'b0;
		case (state_q)
			maft_pkg::CTL_IDLE: in_ready = 1'b1;
			maft_pkg::CTL_SCAN: issue = issue_act_q;
			maft_pkg::CTL_DONE: out_load = !out_valid_q || out_ready;
			default: in_ready = 1'b0;
		endcase
	end

	assign mem_we = out_load && wr_en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= maft_pkg::CTL_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expiry_q <= maft_pkg::EXPIRY_RESET;
		end else if (cfg_wr_en) begin
			expiry_q <= cfg_wr_data;
		end
	end

	// ---------------- entry memory ----------------
	maft_table #(
		.ENTRIES (TABLE_ENTRIES),
		.IDX_W   (IDX_W)
	) u_table (
		.clk     (clk),
		.rd_en   (issue),
		.rd_idx  (rd_idx_q),
		.rd_data (rd_data),
		.wr_en   (mem_we),
		.wr_idx  (wr_idx_q),
		.wr_data (wr_data_q)
	);

	// ---------------- scan compare and decision ----------------
	assign hit      = cmp_act_s1 && cmp_vld_s1 && (rd_data.addr == addr_q);
	assign scan_end = cmp_act_s1 && (hit || (cmp_idx_s1 == LAST_IDX));
	assign age      = now_q - rd_data.created;
	assign expired  = age > {16'd0, expiry_q};

	// A stale hit frees its slot, so the lowest free slot is then at most the hit index.
	always_comb begin
		if (hit) begin
			add_ok  = 1'b1;
			add_idx = (free_found_q && (free_idx_q < cmp_idx_s1)) ? free_idx_q : cmp_idx_s1;
		end else begin
			add_ok  = free_found_q;
			add_idx = free_idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_act_q  <= 1'b0;
			free_found_q <= 1'b0;
			cmp_act_s1   <= 1'b0;
		end else begin
			if (accept) begin
				issue_act_q  <= event_valid &&
					(maft_pkg::kind_t'(event_kind) != maft_pkg::KIND_OTHER);
				free_found_q <= 1'b0;
			end else if (scan_end) begin
				issue_act_q <= 1'b0;
			end else if (issue) begin
				if (rd_idx_q == LAST_IDX)
					issue_act_q <= 1'b0;
				if (!free_found_q && !slot_valid_q[rd_idx_q])
					free_found_q <= 1'b1;
			end
			cmp_act_s1 <= issue && !scan_end;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= maft_pkg::kind_t'(event_kind);
			addr_q   <= dest_addr;
			now_q    <= now_sec;
			rd_idx_q <= '0;
		end else if (issue) begin
			rd_idx_q <= rd_idx_q + 1'b1;
			if (!free_found_q && !slot_valid_q[rd_idx_q])
				free_idx_q <= rd_idx_q;
		end
		cmp_vld_s1 <= slot_valid_q[rd_idx_q];
		cmp_idx_s1 <= rd_idx_q;
	end

	// Outcome registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_en_q   <= 1'b0;
			set_vld_q <= 1'b0;
			clr_vld_q <= 1'b0;
		end else if (accept) begin
			wr_en_q   <= 1'b0;
			set_vld_q <= 1'b0;
			clr_vld_q <= 1'b0;
		end else if (scan_end) begin
			clr_vld_q <= hit && expired;
			if (kind_q == maft_pkg::KIND_HTTP) begin
				wr_en_q   <= !(hit && !expired) && add_ok;
				set_vld_q <= !(hit && !expired) && add_ok;
			end else begin
				wr_en_q   <= hit && !expired && !rd_data.step3;
				set_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_alarm_q  <= 1'b0;
			res_status_q <= event_valid ? maft_pkg::ST_BADKIND : maft_pkg::ST_IGNORED;
		end else if (scan_end) begin
			res_alarm_q <= (kind_q != maft_pkg::KIND_HTTP) && hit && !expired &&
				rd_data.step3;
			set_idx_q   <= add_idx;
			clr_idx_q   <= cmp_idx_s1;
			if (kind_q == maft_pkg::KIND_HTTP) begin
				wr_idx_q  <= add_idx;
				wr_data_q <= '{addr: addr_q, created: now_q, step3: 1'b0};
				if (hit && !expired)
					res_status_q <= maft_pkg::ST_TRACKED;
				else if (add_ok)
					res_status_q <= maft_pkg::ST_ADDED;
				else
					res_status_q <= maft_pkg::ST_FULL;
			end else begin
				wr_idx_q  <= cmp_idx_s1;
				wr_data_q <= '{addr: addr_q, created: rd_data.created, step3: 1'b1};
				if (!hit || expired) begin
					res_status_q <= maft_pkg::ST_UNTRACKED;
				end else if (rd_data.step3) begin
					res_status_q <= maft_pkg::ST_ATTACK;
				end else begin
					res_status_q <= maft_pkg::ST_ADVANCED;
				end
			end
		end
	end

	// Valid marks change only when the outcome is applied; a set wins over a clear.
	always_comb begin
		slot_valid_d = slot_valid_q;
		if (clr_vld_q)
			slot_valid_d[clr_idx_q] = 1'b0;
		if (set_vld_q)
			slot_valid_d[set_idx_q] = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
		end else if (out_load) begin
			slot_valid_q <= slot_valid_d;
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= res_status_q;
			out_alarm_q  <= res_alarm_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign attack_alarm = out_alarm_q;

	// ---------------- assertions ----------------
	a_alarm_only_on_attack: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!attack_alarm || (status == maft_pkg::ST_ATTACK)))
		else $error("alarm raised with a status other than attack");

	a_write_only_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == maft_pkg::CTL_DONE))
		else $error("table write outside of the completion state");

	a_scan_end_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == maft_pkg::CTL_SCAN && scan_end) |=> (state_q == maft_pkg::CTL_DONE))
		else $error("finished scan did not move to completion");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != maft_pkg::CTL_IDLE))
		else $error("accepted event left the controller idle");

	a_compare_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_act_s1 |-> (state_q == maft_pkg::CTL_SCAN))
		else $error("compare stage active outside of a scan");

endmodule

// ----- hdl/maft_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maft_table
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module maft_table #(
	parameter int ENTRIES = maft_pkg::TABLE_ENTRIES_DEF,
	parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic                 clk,
	input  logic                 rd_en,
	input  logic [IDX_W-1:0]     rd_idx,
	output maft_pkg::entry_t     rd_data,
	input  logic                 wr_en,
	input  logic [IDX_W-1:0]     wr_idx,
	input  maft_pkg::entry_t     wr_data
);

	maft_pkg::entry_t mem [ENTRIES];
	maft_pkg::entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_idx];
		end
	end

	assign rd_data = rd_data_q;

endmodule
